>>> sv/imsu_pkg.sv
// Shared widths, codes, result type and reset helpers for the Ising spin update block.
package imsu_pkg;

  localparam int SIDE_DEF  = 64;
  localparam int COORD_W   = 6;
  localparam int FRAC_W    = 16;
  localparam int PROB_W    = 17;
  localparam int ENERGY_W  = 15;
  localparam int MAG_W     = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_TRIAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_DE4 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_DE8 = 1'b1;

  localparam logic [PROB_W-1:0] PROB_RESET = 17'd65536;

  localparam logic signed [ENERGY_W-1:0] DE_NEG8 = -15'sd8;
  localparam logic signed [ENERGY_W-1:0] DE_NEG4 = -15'sd4;
  localparam logic signed [ENERGY_W-1:0] DE_ZERO = 15'sd0;
  localparam logic signed [ENERGY_W-1:0] DE_POS4 = 15'sd4;
  localparam logic signed [ENERGY_W-1:0] DE_POS8 = 15'sd8;

  localparam logic signed [MAG_W-1:0] DM_DOWN = -14'sd2;
  localparam logic signed [MAG_W-1:0] DM_UP   = 14'sd2;
  localparam logic signed [MAG_W-1:0] DM_ZERO = 14'sd0;

  typedef struct packed {
    logic                       flip;
    logic signed [ENERGY_W-1:0] e_delta;
    logic signed [MAG_W-1:0]    m_delta;
  } imsu_eval_t;

  function automatic logic signed [ENERGY_W-1:0] energy_reset(input int side);
    return ENERGY_W'(-2 * side * side);
  endfunction

  function automatic logic signed [MAG_W-1:0] mag_reset(input int side);
    return MAG_W'(side * side);
  endfunction

endpackage

>>> sv/imsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module imsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/imsu_eval.sv
// Flip decision, energy and magnetisation deltas and rewritten row for one site.
module imsu_eval import imsu_pkg::*; #(
  parameter int SIDE = SIDE_DEF,
  localparam int IDX_W = $clog2(SIDE)
) (
  input  logic [SIDE-1:0]   up_row,
  input  logic [SIDE-1:0]   ctr_row,
  input  logic [SIDE-1:0]   dn_row,
  input  logic [IDX_W-1:0]  col,
  input  logic [IDX_W-1:0]  col_l,
  input  logic [IDX_W-1:0]  col_r,
  input  logic              cmd,
  input  logic              spin_value,
  input  logic [FRAC_W-1:0] frac,
  input  logic [PROB_W-1:0] prob_de4,
  input  logic [PROB_W-1:0] prob_de8,
  output imsu_eval_t        res,
  output logic [SIDE-1:0]   new_row
);

  logic                       spin;
  logic [3:0]                 same;
  logic [2:0]                 n_same;
  logic                       trial_ok;
  logic                       flip;
  logic signed [ENERGY_W-1:0] de;
  logic [PROB_W-1:0]          frac_ext;

  always_comb begin
    spin     = ctr_row[col];
    same     = {up_row[col] == spin, dn_row[col] == spin,
                ctr_row[col_l] == spin, ctr_row[col_r] == spin};
    n_same   = 3'(same[0]) + 3'(same[1]) + 3'(same[2]) + 3'(same[3]);
    frac_ext = PROB_W'(frac);
    case (n_same)
      3'd0: begin
        de       = DE_NEG8;
        trial_ok = 1'b1;
      end
      3'd1: begin
        de       = DE_NEG4;
        trial_ok = 1'b1;
      end
      3'd3: begin
        de       = DE_POS4;
        trial_ok = frac_ext <= prob_de4;
      end
      3'd4: begin
        de       = DE_POS8;
        trial_ok = frac_ext <= prob_de8;
      end
      default: begin
        de       = DE_ZERO;
        trial_ok = 1'b1;
      end
    endcase
    if (cmd == CMD_SET) begin
      flip = spin_value != spin;
    end else begin
      flip = trial_ok;
    end
    res.flip    = flip;
    res.e_delta = flip ? de : DE_ZERO;
    res.m_delta = flip ? (spin ? DM_DOWN : DM_UP) : DM_ZERO;
    new_row      = ctr_row;
    new_row[col] = spin ^ flip;
  end

endmodule

>>> sv/ising_metropolis_spin_update.sv
// Top level of the two-dimensional Ising lattice with Metropolis single-spin update.
//
// Input channel (in_*): one beat carries a command, a site and either the value
// to set or a random fraction for a trial. Result channel (out_*): one beat per
// input beat, in order, with the accepted flag and the energy and magnetisation
// after that item. Configuration (cfg_*): a write enable, register index and data
// set the acceptance thresholds; writes take effect at once.
// The lattice is held as rows in three copies of a row-wide RAM, so the rows
// above, at and below the site are read together. The item is registered in
// the evaluation stage and its result in the output register; one item is
// taken every cycle while the receiver does not stall, by the single read-then-write
// pass through the row RAMs. After reset the block sweeps every row to all spins
// up, one row per cycle; in_ready stays low meanwhile.
// When the receiver stalls, the result waits in the output register and one
// further item is held in the evaluation stage before in_ready falls.
module ising_metropolis_spin_update import imsu_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [COORD_W-1:0]         in_row,
  input  logic [COORD_W-1:0]         in_col,
  input  logic                       in_spin_value,
  input  logic [FRAC_W-1:0]          in_random_fraction,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_accepted,
  output logic signed [ENERGY_W-1:0] out_energy,
  output logic signed [MAG_W-1:0]    out_magnetization,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [PROB_W-1:0]          cfg_wdata
);

  localparam int IDX_W = $clog2(SIDE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIDE - 1);
  localparam int COORD_N = 2 ** COORD_W;

  logic [IDX_W-1:0] coord_mod [COORD_N];

  for (genvar g = 0; g < COORD_N; g++) begin : g_mod
    assign coord_mod[g] = IDX_W'(g % SIDE);
  end

  logic [PROB_W-1:0] prob_de4_r;
  logic [PROB_W-1:0] prob_de8_r;

  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_cnt_r;

  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic              s1_spin_r;
  logic [FRAC_W-1:0] s1_frac_r;
  logic [IDX_W-1:0]  s1_row_r;
  logic [IDX_W-1:0]  s1_up_r;
  logic [IDX_W-1:0]  s1_dn_r;
  logic [IDX_W-1:0]  s1_col_r;
  logic [IDX_W-1:0]  s1_cl_r;
  logic [IDX_W-1:0]  s1_cr_r;

  logic             fwd_valid_r;
  logic [IDX_W-1:0] fwd_row_r;
  logic [SIDE-1:0]  fwd_data_r;

  logic signed [ENERGY_W-1:0] energy_r;
  logic signed [ENERGY_W-1:0] energy_nxt;
  logic signed [MAG_W-1:0]    mag_r;
  logic signed [MAG_W-1:0]    mag_nxt;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_accepted_r;
  logic signed [ENERGY_W-1:0] out_energy_r;
  logic signed [MAG_W-1:0]    out_mag_r;

  logic             in_acc;
  logic             s1_adv;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;
  logic [IDX_W-1:0] up_idx;
  logic [IDX_W-1:0] dn_idx;
  logic [IDX_W-1:0] cl_idx;
  logic [IDX_W-1:0] cr_idx;

  logic [SIDE-1:0]  rd_up;
  logic [SIDE-1:0]  rd_ctr;
  logic [SIDE-1:0]  rd_dn;
  logic [SIDE-1:0]  up_row;
  logic [SIDE-1:0]  ctr_row;
  logic [SIDE-1:0]  dn_row;
  logic [SIDE-1:0]  new_row;
  imsu_eval_t       ev;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [SIDE-1:0]  ram_wdata;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    row_idx = coord_mod[in_row];
    col_idx = coord_mod[in_col];
    up_idx  = (row_idx == '0) ? LAST_IDX : row_idx - IDX_W'(1);
    dn_idx  = (row_idx == LAST_IDX) ? '0 : row_idx + IDX_W'(1);
    cl_idx  = (col_idx == '0) ? LAST_IDX : col_idx - IDX_W'(1);
    cr_idx  = (col_idx == LAST_IDX) ? '0 : col_idx + IDX_W'(1);
  end

  assign ram_we    = clr_busy_r || s1_adv;
  assign ram_waddr = clr_busy_r ? clr_cnt_r : s1_row_r;
  assign ram_wdata = clr_busy_r ? {SIDE{1'b1}} : new_row;

  imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_up (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_acc), .raddr(up_idx), .rdata(rd_up)
  );

  imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_ctr (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_acc), .raddr(row_idx), .rdata(rd_ctr)
  );

  imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_dn (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(in_acc), .raddr(dn_idx), .rdata(rd_dn)
  );

  // The write made at the edge of the read is not seen by the read, so the
  // last written row is substituted here.
  always_comb begin
    up_row  = (fwd_valid_r && fwd_row_r == s1_up_r) ? fwd_data_r : rd_up;
    ctr_row = (fwd_valid_r && fwd_row_r == s1_row_r) ? fwd_data_r : rd_ctr;
    dn_row  = (fwd_valid_r && fwd_row_r == s1_dn_r) ? fwd_data_r : rd_dn;
  end

  imsu_eval #(.SIDE(SIDE)) u_eval (
    .up_row(up_row),
    .ctr_row(ctr_row),
    .dn_row(dn_row),
    .col(s1_col_r),
    .col_l(s1_cl_r),
    .col_r(s1_cr_r),
    .cmd(s1_cmd_r),
    .spin_value(s1_spin_r),
    .frac(s1_frac_r),
    .prob_de4(prob_de4_r),
    .prob_de8(prob_de8_r),
    .res(ev),
    .new_row(new_row)
  );

  always_comb begin
    energy_nxt    = energy_r + ev.e_delta;
    mag_nxt       = mag_r + ev.m_delta;
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_de4_r <= PROB_RESET;
      prob_de8_r <= PROB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEPT_DE4: prob_de4_r <= cfg_wdata;
        REG_ACCEPT_DE8: prob_de8_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      energy_r    <= energy_reset(SIDE);
      mag_r       <= mag_reset(SIDE);
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == LAST_IDX) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        fwd_valid_r <= 1'b1;
        energy_r    <= energy_nxt;
        mag_r       <= mag_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_command;
      s1_spin_r <= in_spin_value;
      s1_frac_r <= in_random_fraction;
      s1_row_r  <= row_idx;
      s1_up_r   <= up_idx;
      s1_dn_r   <= dn_idx;
      s1_col_r  <= col_idx;
      s1_cl_r   <= cl_idx;
      s1_cr_r   <= cr_idx;
    end
    if (s1_adv) begin
      fwd_row_r      <= s1_row_r;
      fwd_data_r     <= new_row;
      out_accepted_r <= ev.flip;
      out_energy_r   <= energy_nxt;
      out_mag_r      <= mag_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_energy        = out_energy_r;
  assign out_magnetization = out_mag_r;

endmodule

>>> sv/imsu_checker.sv
// Port-level checker for the Ising spin update block and its bind statement.
module imsu_checker import imsu_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_command,
  input logic [COORD_W-1:0]         in_row,
  input logic [COORD_W-1:0]         in_col,
  input logic                       in_spin_value,
  input logic [FRAC_W-1:0]          in_random_fraction,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_accepted,
  input logic signed [ENERGY_W-1:0] out_energy,
  input logic signed [MAG_W-1:0]    out_magnetization,
  input logic                       cfg_we,
  input logic [CFG_IDX_W-1:0]       cfg_index,
  input logic [PROB_W-1:0]          cfg_wdata
);

  localparam logic signed [ENERGY_W-1:0] E_RST = energy_reset(SIDE);
  localparam logic signed [MAG_W-1:0]    M_RST = mag_reset(SIDE);

  logic signed [ENERGY_W-1:0] prev_e_r;
  logic signed [MAG_W-1:0]    prev_m_r;
  logic [MAG_W-1:0]           m_step;

  assign m_step = MAG_W'(out_magnetization - prev_m_r);

  // The last delivered totals; an unaccepted beat must repeat them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_e_r <= E_RST;
      prev_m_r <= M_RST;
    end else if (out_valid && out_ready) begin
      prev_e_r <= out_energy;
      prev_m_r <= out_magnetization;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during the lattice clearing sweep");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy)
      && $stable(out_magnetization) && $stable(out_accepted))
    else $error("stalled result beat changed");

  a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_energy == prev_e_r
      && out_magnetization == prev_m_r)
    else $error("totals changed without an accepted flip");

  a_mag_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> m_step == MAG_W'(2) || m_step == MAG_W'(-2))
    else $error("accepted flip did not move magnetisation by two");

  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_energy[1:0] == E_RST[1:0]
      && out_magnetization[0] == M_RST[0])
    else $error("energy or magnetisation left its lattice of values");

endmodule

bind ising_metropolis_spin_update imsu_checker #(.SIDE(SIDE)) u_imsu_checker (.*);
